[rtl/bfst_pkg.sv]
package bfst_pkg;

    typedef struct packed {
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] dh;
        logic [63:0] dl;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [31:0] last;
    } bfst_tag_t;

    typedef enum logic [2:0] {
        ALU_PASSA = 3'd0,
        ALU_PASSB = 3'd1,
        ALU_ADD   = 3'd2,
        ALU_SUB   = 3'd3,
        ALU_MIN   = 3'd4,
        ALU_MAX   = 3'd5,
        ALU_INC16 = 3'd6
    } bfst_alu_op_t;

    localparam logic [1:0] STS_MATCH   = 2'd0;
    localparam logic [1:0] STS_CREATED = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;
    localparam logic [1:0] STS_READ    = 2'd3;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_IDLEGAP = 1'b1;

    localparam logic [4:0] W_START    = 5'd0;
    localparam logic [4:0] W_LAST     = 5'd1;
    localparam logic [4:0] W_LAST_F   = 5'd2;
    localparam logic [4:0] W_LAST_B   = 5'd3;
    localparam logic [4:0] W_PKT_F    = 5'd4;
    localparam logic [4:0] W_PKT_B    = 5'd5;
    localparam logic [4:0] W_PKT_T    = 5'd6;
    localparam logic [4:0] W_BYTE_F   = 5'd7;
    localparam logic [4:0] W_BYTE_B   = 5'd8;
    localparam logic [4:0] W_BYTE_T   = 5'd9;
    localparam logic [4:0] W_LMIN_F   = 5'd10;
    localparam logic [4:0] W_LMAX_F   = 5'd11;
    localparam logic [4:0] W_LSUM_F   = 5'd12;
    localparam logic [4:0] W_LMIN_B   = 5'd13;
    localparam logic [4:0] W_LMAX_B   = 5'd14;
    localparam logic [4:0] W_LSUM_B   = 5'd15;
    localparam logic [4:0] W_ISUM_F   = 5'd16;
    localparam logic [4:0] W_IMIN_F   = 5'd17;
    localparam logic [4:0] W_IMAX_F   = 5'd18;
    localparam logic [4:0] W_ISUM_B   = 5'd19;
    localparam logic [4:0] W_IMIN_B   = 5'd20;
    localparam logic [4:0] W_IMAX_B   = 5'd21;
    localparam logic [4:0] W_SYN      = 5'd22;
    localparam logic [4:0] W_FIN      = 5'd23;
    localparam logic [4:0] W_RST      = 5'd24;
    localparam logic [4:0] W_PSH      = 5'd25;
    localparam logic [4:0] W_ACK      = 5'd26;
    localparam logic [4:0] W_URG      = 5'd27;
    localparam logic [4:0] W_ACTIVE   = 5'd28;
    localparam logic [4:0] W_IDLE     = 5'd29;
    localparam logic [4:0] W_LAST_ACT = 5'd30;
    localparam logic [4:0] W_LABEL    = 5'd31;

    localparam int STAT_WORDS = 32;

endpackage

[rtl/bfst_alu.sv]
module bfst_alu
    import bfst_pkg::*;
(
    input  bfst_alu_op_t op,
    input  logic [31:0]  a,
    input  logic [31:0]  b,
    output logic [31:0]  res
);

    logic        a_lt_b;
    logic [31:0] sum;

    assign a_lt_b = a < b;
    assign sum    = a + ((op == ALU_SUB) ? (~b + 32'd1) : b);

    always_comb
    begin
        case (op)
            ALU_PASSA: res = a;
            ALU_PASSB: res = b;
            ALU_ADD:   res = sum;
            ALU_SUB:   res = sum;
            ALU_MIN:   res = a_lt_b ? a : b;
            ALU_MAX:   res = a_lt_b ? b : a;
            ALU_INC16: res = {16'd0, a[15:0] + 16'd1};
            default:   res = a;
        endcase
    end

endmodule

[rtl/bidirectional_flow_stats_table.sv]
// Flow table of FLOW_SLOTS slots keyed by the IPv6/port 4-tuple in either direction, with 32
// statistic words per slot. A packet beat scans the tag rows, stopping at a match and covering
// every slot when no flow matches; a matched flow then fetches its previous timestamps in
// S_PRE0, S_PRE1 and S_PRE2, and the sweep rewrites the slot's statistic words. A new flow
// claims the first free slot and goes straight to the sweep. A table-full drop ends right
// after the scan. The block returns to S_IDLE after each result before it takes the next beat;
// a read beat is answered from S_RD. A result that finds the previous one still waiting for
// out_ready holds until that one is taken. The tag memory is read one slot per cycle, and the
// statistics words pass one per cycle through a single shared 32-bit ALU.
// The block takes no new beat while a packet or read is in progress.
module bidirectional_flow_stats_table
    import bfst_pkg::*;
#(
    parameter int FLOW_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] src_addr_high,
    input  logic [63:0] src_addr_low,
    input  logic [63:0] dst_addr_high,
    input  logic [63:0] dst_addr_low,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [15:0] packet_length,
    input  logic [7:0]  flag_bits,
    input  logic        attack_mark,
    input  logic [31:0] timestamp,
    input  logic [10:0] stat_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  slot_index,
    output logic [1:0]  status,
    output logic        forward_dir,
    output logic [31:0] flow_packets,
    output logic [31:0] stat_value
);

    localparam int SW  = $clog2(FLOW_SLOTS);
    localparam int CW  = SW + 1;
    localparam int SAW = SW + 5;
    localparam logic [CW-1:0] NSLOT = CW'(FLOW_SLOTS);
    localparam logic [6:0]    NSLOT7 = 7'(FLOW_SLOTS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PRE0  = 7'b0001000,
        S_PRE1  = 7'b0010000,
        S_PRE2  = 7'b0100000,
        S_SWEEP = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] timeout_reg, idle_reg;
    logic [FLOW_SLOTS-1:0] valid_reg, valid_next;

    logic [CW-1:0] iss_reg, iss_next;
    logic          cvld_reg, cvld_next;
    logic [SW-1:0] cidx_reg, cidx_next;
    logic          ffound_reg, ffound_next;
    logic [SW-1:0] fidx_reg, fidx_next;
    logic [5:0]    wiss_reg, wiss_next;
    logic          wvld_reg, wvld_next;
    logic [4:0]    widx_reg, widx_next;
    logic          out_valid_reg;

    // captured beat
    logic [63:0] sh_reg, sl_reg, dh_reg, dl_reg;
    logic [15:0] sp_reg, dp_reg, len_reg;
    logic [7:0]  fl_reg;
    logic        atk_reg;
    logic [31:0] now_reg;
    logic [5:0]  rslot_reg;
    logic        rinr_reg;

    logic [SW-1:0] slot_reg, slot_next;
    logic          fwd_reg, fwd_next;
    logic          claim_reg, claim_next;
    logic [31:0]   d_reg, d_next, gap_reg, gap_next, pkt_reg, pkt_next;
    logic          dv_reg, dv_next, gv_reg, gv_next, gidle_reg, gidle_next;

    logic [5:0]  oslot_reg, oslot_next;
    logic [1:0]  osts_reg, osts_next;
    logic        ofwd_reg, ofwd_next;
    logic [31:0] opkt_reg, opkt_next, oval_reg, oval_next;
    logic        produce;

    // memories
    bfst_tag_t   tag_mem [FLOW_SLOTS];
    bfst_tag_t   tag_rd_reg, tag_wdata;
    logic        tag_re, tag_we;
    logic [SW-1:0] tag_raddr, tag_waddr;
    logic [31:0] stat_mem [FLOW_SLOTS*STAT_WORDS];
    logic [31:0] stat_rd_reg, stat_wdata;
    logic        stat_re, stat_we;
    logic [SAW-1:0] stat_raddr, stat_waddr;

    bfst_alu_op_t alu_op, w_op;
    logic [31:0]  alu_a, alu_b, alu_res, w_b, w_init, w_old;

    logic accept, out_free, fmatch, rmatch;

    bfst_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign fmatch = tag_rd_reg.sh == sh_reg && tag_rd_reg.sl == sl_reg &&
                    tag_rd_reg.dh == dh_reg && tag_rd_reg.dl == dl_reg &&
                    tag_rd_reg.sp == sp_reg && tag_rd_reg.dp == dp_reg;
    assign rmatch = tag_rd_reg.sh == dh_reg && tag_rd_reg.sl == dl_reg &&
                    tag_rd_reg.dh == sh_reg && tag_rd_reg.dl == sl_reg &&
                    tag_rd_reg.sp == dp_reg && tag_rd_reg.dp == sp_reg;

    // per-word update rule of the sweep
    always_comb
    begin
        w_op   = ALU_PASSA;
        w_b    = now_reg;
        w_init = 32'd0;
        case (widx_reg)
            W_START:    w_init = now_reg;
            W_LAST:     begin w_op = ALU_PASSB; w_init = now_reg; end
            W_LAST_F:   w_op = fwd_reg ? ALU_PASSB : ALU_PASSA;
            W_LAST_B:   w_op = fwd_reg ? ALU_PASSA : ALU_PASSB;
            W_PKT_F:    begin w_op = fwd_reg ? ALU_ADD : ALU_PASSA; w_b = 32'd1; end
            W_PKT_B:    begin w_op = fwd_reg ? ALU_PASSA : ALU_ADD; w_b = 32'd1; end
            W_PKT_T:    begin w_op = ALU_ADD; w_b = 32'd1; end
            W_BYTE_F:   begin w_op = fwd_reg ? ALU_ADD : ALU_PASSA; w_b = {16'd0, len_reg}; end
            W_BYTE_B:   begin w_op = fwd_reg ? ALU_PASSA : ALU_ADD; w_b = {16'd0, len_reg}; end
            W_BYTE_T:   begin w_op = ALU_ADD; w_b = {16'd0, len_reg}; end
            W_LMIN_F:
            begin
                w_op = fwd_reg ? ALU_MIN : ALU_PASSA; w_b = {16'd0, len_reg};
                w_init = 32'h0000FFFF;
            end
            W_LMAX_F:   begin w_op = fwd_reg ? ALU_MAX : ALU_PASSA; w_b = {16'd0, len_reg}; end
            W_LSUM_F:   begin w_op = fwd_reg ? ALU_ADD : ALU_PASSA; w_b = {16'd0, len_reg}; end
            W_LMIN_B:
            begin
                w_op = fwd_reg ? ALU_PASSA : ALU_MIN; w_b = {16'd0, len_reg};
                w_init = 32'h0000FFFF;
            end
            W_LMAX_B:   begin w_op = fwd_reg ? ALU_PASSA : ALU_MAX; w_b = {16'd0, len_reg}; end
            W_LSUM_B:   begin w_op = fwd_reg ? ALU_PASSA : ALU_ADD; w_b = {16'd0, len_reg}; end
            W_ISUM_F:   begin w_op = (fwd_reg && dv_reg) ? ALU_ADD : ALU_PASSA; w_b = d_reg; end
            W_IMIN_F:
            begin
                w_op = (fwd_reg && dv_reg) ? ALU_MIN : ALU_PASSA; w_b = d_reg;
                w_init = 32'hFFFFFFFF;
            end
            W_IMAX_F:   begin w_op = (fwd_reg && dv_reg) ? ALU_MAX : ALU_PASSA; w_b = d_reg; end
            W_ISUM_B:   begin w_op = (!fwd_reg && dv_reg) ? ALU_ADD : ALU_PASSA; w_b = d_reg; end
            W_IMIN_B:
            begin
                w_op = (!fwd_reg && dv_reg) ? ALU_MIN : ALU_PASSA; w_b = d_reg;
                w_init = 32'hFFFFFFFF;
            end
            W_IMAX_B:   begin w_op = (!fwd_reg && dv_reg) ? ALU_MAX : ALU_PASSA; w_b = d_reg; end
            W_SYN:      w_op = fl_reg[1] ? ALU_INC16 : ALU_PASSA;
            W_FIN:      w_op = fl_reg[0] ? ALU_INC16 : ALU_PASSA;
            W_RST:      w_op = fl_reg[2] ? ALU_INC16 : ALU_PASSA;
            W_PSH:      w_op = fl_reg[3] ? ALU_INC16 : ALU_PASSA;
            W_ACK:      w_op = fl_reg[4] ? ALU_INC16 : ALU_PASSA;
            W_URG:      w_op = fl_reg[5] ? ALU_INC16 : ALU_PASSA;
            W_ACTIVE:   begin w_op = (gv_reg && !gidle_reg) ? ALU_ADD : ALU_PASSA; w_b = gap_reg; end
            W_IDLE:     begin w_op = (gv_reg && gidle_reg) ? ALU_ADD : ALU_PASSA; w_b = gap_reg; end
            W_LAST_ACT: w_op = ALU_PASSB;
            W_LABEL:    begin w_op = atk_reg ? ALU_PASSB : ALU_PASSA; w_b = 32'd1; end
            default:    w_op = ALU_PASSA;
        endcase
    end

    assign w_old = claim_reg ? w_init : stat_rd_reg;

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        iss_next    = iss_reg;
        cvld_next   = cvld_reg;
        cidx_next   = cidx_reg;
        ffound_next = ffound_reg;
        fidx_next   = fidx_reg;
        wiss_next   = wiss_reg;
        wvld_next   = wvld_reg;
        widx_next   = widx_reg;
        slot_next   = slot_reg;
        fwd_next    = fwd_reg;
        claim_next  = claim_reg;
        d_next      = d_reg;
        dv_next     = dv_reg;
        gap_next    = gap_reg;
        gv_next     = gv_reg;
        gidle_next  = gidle_reg;
        pkt_next    = pkt_reg;
        produce     = 1'b0;
        oslot_next  = oslot_reg;
        osts_next   = osts_reg;
        ofwd_next   = 1'b0;
        opkt_next   = 32'd0;
        oval_next   = 32'd0;
        tag_re      = 1'b0;
        tag_raddr   = iss_reg[SW-1:0];
        tag_we      = 1'b0;
        tag_waddr   = cidx_reg;
        tag_wdata   = '{sh: sh_reg, sl: sl_reg, dh: dh_reg, dl: dl_reg,
                        sp: sp_reg, dp: dp_reg, last: now_reg};
        stat_re     = 1'b0;
        stat_raddr  = stat_address[SAW-1:0];
        stat_we     = 1'b0;
        stat_waddr  = {slot_reg, widx_reg};
        stat_wdata  = alu_res;
        alu_op      = ALU_SUB;
        alu_a       = now_reg;
        alu_b       = tag_rd_reg.last;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func)
                    begin
                        stat_re    = stat_address[10:5] < NSLOT7[5:0] || NSLOT7[6];
                        state_next = S_RD;
                    end
                    else
                    begin
                        iss_next    = '0;
                        cvld_next   = 1'b0;
                        ffound_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_RD:
            begin
                if (out_free)
                begin
                    produce    = 1'b1;
                    oslot_next = rslot_reg;
                    osts_next  = STS_READ;
                    oval_next  = rinr_reg ? stat_rd_reg : 32'd0;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (cvld_reg && valid_reg[cidx_reg] && alu_res <= timeout_reg &&
                    (fmatch || rmatch))
                begin
                    // hit: refresh the last-seen time in the tag row
                    slot_next  = cidx_reg;
                    fwd_next   = tag_rd_reg.sh == sh_reg && tag_rd_reg.sl == sl_reg;
                    claim_next = 1'b0;
                    tag_we     = 1'b1;
                    tag_wdata  = tag_rd_reg;
                    tag_wdata.last = now_reg;
                    state_next = S_PRE0;
                end
                else
                begin
                    if (cvld_reg)
                    begin
                        if (valid_reg[cidx_reg])
                        begin
                            if (alu_res > timeout_reg)
                            begin
                                valid_next[cidx_reg] = 1'b0;
                                if (!ffound_reg)
                                begin
                                    ffound_next = 1'b1;
                                    fidx_next   = cidx_reg;
                                end
                            end
                        end
                        else if (!ffound_reg)
                        begin
                            ffound_next = 1'b1;
                            fidx_next   = cidx_reg;
                        end
                    end
                    if (iss_reg < NSLOT)
                    begin
                        tag_re    = 1'b1;
                        cvld_next = 1'b1;
                        cidx_next = iss_reg[SW-1:0];
                        iss_next  = iss_reg + CW'(1);
                    end
                    else if (cvld_reg)
                    begin
                        cvld_next = 1'b0;
                    end
                    else if (ffound_reg)
                    begin
                        // claim the first free slot
                        slot_next   = fidx_reg;
                        fwd_next    = 1'b1;
                        claim_next  = 1'b1;
                        dv_next     = 1'b0;
                        gv_next     = 1'b0;
                        gidle_next  = 1'b0;
                        valid_next[fidx_reg] = 1'b1;
                        tag_we      = 1'b1;
                        tag_waddr   = fidx_reg;
                        wiss_next   = '0;
                        wvld_next   = 1'b0;
                        state_next  = S_SWEEP;
                    end
                    else if (out_free)
                    begin
                        produce    = 1'b1;
                        oslot_next = 6'd0;
                        osts_next  = STS_FULL;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PRE0:
            begin
                stat_re    = 1'b1;
                stat_raddr = {slot_reg, fwd_reg ? W_LAST_F : W_LAST_B};
                state_next = S_PRE1;
            end
            S_PRE1:
            begin
                stat_re    = 1'b1;
                stat_raddr = {slot_reg, W_LAST_ACT};
                alu_b      = stat_rd_reg;
                d_next     = alu_res;
                dv_next    = stat_rd_reg != 32'd0;
                state_next = S_PRE2;
            end
            S_PRE2:
            begin
                alu_b      = stat_rd_reg;
                gap_next   = alu_res;
                gv_next    = stat_rd_reg != 32'd0;
                gidle_next = alu_res > idle_reg;
                wiss_next  = '0;
                wvld_next  = 1'b0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                alu_op = w_op;
                alu_a  = w_old;
                alu_b  = w_b;
                if (wvld_reg)
                begin
                    stat_we = 1'b1;
                    if (widx_reg == W_PKT_T)
                    begin
                        pkt_next = alu_res;
                    end
                end
                if (wiss_reg < 6'(STAT_WORDS))
                begin
                    stat_re    = 1'b1;
                    stat_raddr = {slot_reg, wiss_reg[4:0]};
                    wvld_next  = 1'b1;
                    widx_next  = wiss_reg[4:0];
                    wiss_next  = wiss_reg + 6'd1;
                end
                else if (wvld_reg)
                begin
                    wvld_next = 1'b0;
                end
                else if (out_free)
                begin
                    produce    = 1'b1;
                    oslot_next = 6'(slot_reg);
                    osts_next  = claim_reg ? STS_CREATED : STS_MATCH;
                    ofwd_next  = fwd_reg;
                    opkt_next  = pkt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timeout_reg   <= 32'd7680;
            idle_reg      <= 32'd128;
            valid_reg     <= '0;
            iss_reg       <= '0;
            cvld_reg      <= 1'b0;
            ffound_reg    <= 1'b0;
            wiss_reg      <= '0;
            wvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            iss_reg    <= iss_next;
            cvld_reg   <= cvld_next;
            ffound_reg <= ffound_next;
            wiss_reg   <= wiss_next;
            wvld_reg   <= wvld_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
                if (cfg_index == CFG_IDLEGAP)
                begin
                    idle_reg <= cfg_data;
                end
            end
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sh_reg    <= src_addr_high;
            sl_reg    <= src_addr_low;
            dh_reg    <= dst_addr_high;
            dl_reg    <= dst_addr_low;
            sp_reg    <= source_port;
            dp_reg    <= destination_port;
            len_reg   <= packet_length;
            fl_reg    <= flag_bits;
            atk_reg   <= attack_mark;
            now_reg   <= timestamp;
            rslot_reg <= stat_address[10:5];
            rinr_reg  <= {1'b0, stat_address[10:5]} < NSLOT7;
        end
        cidx_reg  <= cidx_next;
        fidx_reg  <= fidx_next;
        widx_reg  <= widx_next;
        slot_reg  <= slot_next;
        fwd_reg   <= fwd_next;
        claim_reg <= claim_next;
        d_reg     <= d_next;
        dv_reg    <= dv_next;
        gap_reg   <= gap_next;
        gv_reg    <= gv_next;
        gidle_reg <= gidle_next;
        pkt_reg   <= pkt_next;
        if (produce)
        begin
            oslot_reg <= oslot_next;
            osts_reg  <= osts_next;
            ofwd_reg  <= ofwd_next;
            opkt_reg  <= opkt_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (tag_re)
        begin
            tag_rd_reg <= tag_mem[tag_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
        if (stat_re)
        begin
            stat_rd_reg <= stat_mem[stat_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_index   = oslot_reg;
    assign status       = osts_reg;
    assign forward_dir  = ofwd_reg;
    assign flow_packets = opkt_reg;
    assign stat_value   = oval_reg;

    // a matched slot must still be live when its statistics are fetched
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PRE0 |-> valid_reg[slot_reg])
        else $error("matched slot is not valid");

    // the free candidate stays free for the rest of the scan
    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ffound_reg) |-> !valid_reg[fidx_reg])
        else $error("free candidate is occupied");

    // statistics are written only by the sweep
    a_stat_wr: assert property (@(posedge clk) disable iff (!rst_n)
        stat_we |-> state_reg == S_SWEEP)
        else $error("statistic write outside sweep");

    // a created or matched result always leaves its slot live
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && state_reg == S_SWEEP) |=> valid_reg[slot_reg])
        else $error("updated slot not valid");

endmodule

[tb/flow_table_checker.sv]
module flow_table_checker
    import bfst_pkg::*;
#(
    parameter int FLOW_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [63:0] src_addr_high,
    input  logic [63:0] src_addr_low,
    input  logic [63:0] dst_addr_high,
    input  logic [63:0] dst_addr_low,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [15:0] packet_length,
    input  logic [7:0]  flag_bits,
    input  logic        attack_mark,
    input  logic [31:0] timestamp,
    input  logic [10:0] stat_address,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  slot_index,
    input  logic [1:0]  status,
    input  logic        forward_dir,
    input  logic [31:0] flow_packets,
    input  logic [31:0] stat_value,
    output int          error_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [5:0]  slot;
        bit [1:0]  sts;
        bit        fwd;
        bit [31:0] pkts;
        bit [31:0] value;
    } flow_result_t;

    flow_result_t result_queue[$];

    bit [31:0] timeout_ticks;
    bit [31:0] gap_ticks;
    bit        live[FLOW_SLOTS];
    bit [63:0] key_sh[FLOW_SLOTS];
    bit [63:0] key_sl[FLOW_SLOTS];
    bit [63:0] key_dh[FLOW_SLOTS];
    bit [63:0] key_dl[FLOW_SLOTS];
    bit [15:0] key_sp[FLOW_SLOTS];
    bit [15:0] key_dp[FLOW_SLOTS];
    bit [31:0] words[FLOW_SLOTS][STAT_WORDS];

    assign pending = result_queue.size();

    task automatic report_mismatch(input string what, input bit [31:0] got,
                                   input bit [31:0] want);
        $display("%0t: MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void side_update(input int s, input int pk, input int by,
                                        input int lst, input int lb, input int ib,
                                        input bit [31:0] len, input bit [31:0] now);
        bit [31:0] d;
        words[s][pk] = words[s][pk] + 1;
        words[s][by] = words[s][by] + len;
        if (len < words[s][lb]) words[s][lb] = len;
        if (len > words[s][lb+1]) words[s][lb+1] = len;
        words[s][lb+2] = words[s][lb+2] + len;
        // a zero last time means this direction has no earlier packet
        if (words[s][lst] != 0)
        begin
            d = now - words[s][lst];
            words[s][ib] = words[s][ib] + d;
            if (d < words[s][ib+1]) words[s][ib+1] = d;
            if (d > words[s][ib+2]) words[s][ib+2] = d;
        end
        words[s][lst] = now;
    endfunction

    function automatic void bump_flag(input int s, input int w);
        words[s][w] = (words[s][w] + 1) & 32'h0000_FFFF;
    endfunction

    function automatic flow_result_t predict_beat();
        flow_result_t r;
        int hit;
        bit [31:0] now;
        bit [31:0] len;
        bit [31:0] gap;
        bit fwd_match;
        bit rev_match;
        r = '{default: '0};
        hit = -1;
        now = timestamp;
        len = {16'h0, packet_length};
        if (func)
        begin
            r.slot = stat_address[10:5];
            r.sts = STS_READ;
            if (int'(stat_address[10:5]) < FLOW_SLOTS)
                r.value = words[stat_address[10:5]][stat_address[4:0]];
            return r;
        end
        for (int i = 0; i < FLOW_SLOTS; i++)
        begin
            if (!live[i]) continue;
            if (now - words[i][W_LAST] > timeout_ticks)
            begin
                live[i] = 1'b0;
                continue;
            end
            fwd_match = key_sh[i] == src_addr_high && key_sl[i] == src_addr_low &&
                        key_dh[i] == dst_addr_high && key_dl[i] == dst_addr_low &&
                        key_sp[i] == source_port && key_dp[i] == destination_port;
            rev_match = key_sh[i] == dst_addr_high && key_sl[i] == dst_addr_low &&
                        key_dh[i] == src_addr_high && key_dl[i] == src_addr_low &&
                        key_sp[i] == destination_port && key_dp[i] == source_port;
            if (fwd_match || rev_match)
            begin
                hit = i;
                break;
            end
        end
        r.sts = STS_MATCH;
        if (hit < 0)
        begin
            for (int i = 0; i < FLOW_SLOTS; i++)
            begin
                if (!live[i])
                begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0)
            begin
                r.sts = STS_FULL;
                return r;
            end
            for (int w = 0; w < STAT_WORDS; w++) words[hit][w] = '0;
            key_sh[hit] = src_addr_high;
            key_sl[hit] = src_addr_low;
            key_dh[hit] = dst_addr_high;
            key_dl[hit] = dst_addr_low;
            key_sp[hit] = source_port;
            key_dp[hit] = destination_port;
            words[hit][W_START] = now;
            words[hit][W_LAST] = now;
            words[hit][W_LMIN_F] = 32'h0000_FFFF;
            words[hit][W_LMIN_B] = 32'h0000_FFFF;
            words[hit][W_IMIN_F] = 32'hFFFF_FFFF;
            words[hit][W_IMIN_B] = 32'hFFFF_FFFF;
            live[hit] = 1'b1;
            r.sts = STS_CREATED;
        end
        // direction follows the source address only
        r.fwd = key_sh[hit] == src_addr_high && key_sl[hit] == src_addr_low;
        words[hit][W_PKT_T] = words[hit][W_PKT_T] + 1;
        words[hit][W_BYTE_T] = words[hit][W_BYTE_T] + len;
        if (r.fwd)
            side_update(hit, W_PKT_F, W_BYTE_F, W_LAST_F, W_LMIN_F, W_ISUM_F, len, now);
        else
            side_update(hit, W_PKT_B, W_BYTE_B, W_LAST_B, W_LMIN_B, W_ISUM_B, len, now);
        if (flag_bits[1]) bump_flag(hit, W_SYN);
        if (flag_bits[0]) bump_flag(hit, W_FIN);
        if (flag_bits[2]) bump_flag(hit, W_RST);
        if (flag_bits[3]) bump_flag(hit, W_PSH);
        if (flag_bits[4]) bump_flag(hit, W_ACK);
        if (flag_bits[5]) bump_flag(hit, W_URG);
        if (words[hit][W_LAST_ACT] != 0)
        begin
            gap = now - words[hit][W_LAST_ACT];
            if (gap > gap_ticks) words[hit][W_IDLE] = words[hit][W_IDLE] + gap;
            else words[hit][W_ACTIVE] = words[hit][W_ACTIVE] + gap;
        end
        words[hit][W_LAST_ACT] = now;
        words[hit][W_LAST] = now;
        if (attack_mark) words[hit][W_LABEL] = 32'd1;
        r.slot = hit[5:0];
        r.pkts = words[hit][W_PKT_T];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t want;
        if (!rst_n)
        begin
            timeout_ticks = 32'd7680;
            gap_ticks = 32'd128;
            for (int i = 0; i < FLOW_SLOTS; i++) live[i] = 1'b0;
            result_queue.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT) timeout_ticks = cfg_data;
                else gap_ticks = cfg_data;
            end
            // compare before predicting: a result never belongs to the beat of the same edge
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                    report_mismatch("result with nothing expected", {30'h0, status}, '0);
                else
                begin
                    want = result_queue.pop_front();
                    if (slot_index !== want.slot)
                        report_mismatch("slot_index", 32'(slot_index), 32'(want.slot));
                    if (status !== want.sts)
                        report_mismatch("status", 32'(status), 32'(want.sts));
                    if (forward_dir !== want.fwd)
                        report_mismatch("forward_dir", 32'(forward_dir), 32'(want.fwd));
                    if (flow_packets !== want.pkts)
                        report_mismatch("flow_packets", flow_packets, want.pkts);
                    if (stat_value !== want.value)
                        report_mismatch("stat_value", stat_value, want.value);
                end
            end
            if (in_valid && in_ready)
                result_queue.push_back(predict_beat());
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import bfst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        bit [63:0] sh;
        bit [63:0] sl;
        bit [63:0] dh;
        bit [63:0] dl;
        bit [15:0] sp;
        bit [15:0] dp;
    } flow_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_TIMEOUT;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [63:0] src_addr_high = '0;
    logic [63:0] src_addr_low = '0;
    logic [63:0] dst_addr_high = '0;
    logic [63:0] dst_addr_low = '0;
    logic [15:0] source_port = '0;
    logic [15:0] destination_port = '0;
    logic [15:0] packet_length = '0;
    logic [7:0]  flag_bits = '0;
    logic        attack_mark = 1'b0;
    logic [31:0] timestamp = '0;
    logic [10:0] stat_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  slot_index;
    logic [1:0]  status;
    logic        forward_dir;
    logic [31:0] flow_packets;
    logic [31:0] stat_value;

    int          error_count;
    int          pending;
    bit [63:0]   claimed_slots = '0;
    int          n_created = 0;
    int          n_matched = 0;
    int          n_full = 0;
    int          n_reads = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    bit [31:0]   tick = 32'd0;
    flow_key_t   flow_pool[16];

    bidirectional_flow_stats_table dut (.*);

    flow_table_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: alternate between always ready, coin flip, and heavy stall
    always @(posedge clk or negedge rst_n)
    begin
        int mode;
        int run_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            mode = 0;
            run_left = 0;
        end
        else
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 2);
                run_left = $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            case (status)
                STS_CREATED:
                begin
                    claimed_slots[slot_index] <= 1'b1;
                    n_created++;
                end
                STS_MATCH: n_matched++;
                STS_FULL: n_full++;
                default: n_reads++;
            endcase
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic flow_key_t random_key();
        flow_key_t k;
        k.sh = {$urandom, $urandom};
        k.sl = {$urandom, $urandom};
        k.dh = {$urandom, $urandom};
        k.dl = {$urandom, $urandom};
        k.sp = 16'($urandom_range(0, 65535));
        k.dp = 16'($urandom_range(0, 65535));
        return k;
    endfunction

    // hold valid across a burst; lower it only for a real gap
    task automatic present_beat();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    task automatic send_packet(input flow_key_t k, input bit swap, input bit [31:0] at,
                               input bit [15:0] len, input bit [7:0] flags,
                               input bit atk);
        func <= 1'b0;
        src_addr_high <= swap ? k.dh : k.sh;
        src_addr_low <= swap ? k.dl : k.sl;
        dst_addr_high <= swap ? k.sh : k.dh;
        dst_addr_low <= swap ? k.sl : k.dl;
        source_port <= swap ? k.dp : k.sp;
        destination_port <= swap ? k.sp : k.dp;
        packet_length <= len;
        flag_bits <= flags;
        attack_mark <= atk;
        timestamp <= at;
        stat_address <= 11'($urandom);
        present_beat();
    endtask

    task automatic send_read(input bit [5:0] slot, input bit [4:0] word);
        func <= 1'b1;
        stat_address <= {slot, word};
        {src_addr_high, src_addr_low} <= {$urandom, $urandom, $urandom, $urandom};
        timestamp <= $urandom;
        present_beat();
    endtask

    task automatic send_random_read();
        bit [5:0] slot;
        do slot = 6'($urandom_range(0, 63)); while (!claimed_slots[slot]);
        send_read(slot, 5'($urandom_range(0, 31)));
    endtask

    task automatic send_pool_packet(input int pool_size, input int step_max);
        tick = tick + $urandom_range(1, step_max);
        send_packet(flow_pool[$urandom_range(0, pool_size - 1)], 1'($urandom_range(0, 1)),
                    tick, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 15) == 0);
    endtask

    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_registers(input bit [31:0] timeout_val, input bit [31:0] gap_val);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= timeout_val;
        @(posedge clk);
        cfg_index <= CFG_IDLEGAP;
        cfg_data <= gap_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        flow_key_t a;
        flow_key_t loop;
        flow_key_t ones;
        flow_key_t zeros;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers
        a = random_key();
        loop = random_key();
        loop.dh = loop.sh;
        loop.dl = loop.sl;
        ones = '{default: '1};
        zeros = '{default: '0};
        send_packet(a, 1'b0, 32'd0, 16'd0, 8'hFF, 1'b0);
        send_packet(a, 1'b1, 32'd50, 16'hFFFF, 8'h3F, 1'b0);
        send_packet(a, 1'b0, 32'd100, 16'd40, 8'h02, 1'b0);
        send_packet(a, 1'b0, 32'd400, 16'd1500, 8'h10, 1'b1);
        send_packet(a, 1'b1, 32'd420, 16'd1, 8'h00, 1'b0);
        send_packet(loop, 1'b0, 32'd500, 16'd64, 8'h01, 1'b0);
        send_packet(loop, 1'b1, 32'd510, 16'd64, 8'h04, 1'b0);
        send_packet(ones, 1'b0, 32'd600, 16'hFFFF, 8'h08, 1'b1);
        send_packet(zeros, 1'b0, 32'd700, 16'd0, 8'h20, 1'b0);
        send_packet(zeros, 1'b1, 32'd900, 16'd7, 8'hC0, 1'b0);
        // jump past the timeout: the scan frees every earlier flow
        send_packet(a, 1'b1, 32'd20000, 16'd9, 8'h12, 1'b0);
        send_packet(ones, 1'b0, 32'hFFFF_FFFF, 16'd3, 8'h00, 1'b0);
        send_packet(ones, 1'b0, 32'd5, 16'd3, 8'h00, 1'b0);
        drain();
        send_read(6'd0, W_START);
        send_read(6'd0, W_PKT_T);
        send_read(6'd0, W_LABEL);
        send_read(6'd1, W_SYN);
        send_read(6'd2, W_IMIN_F);
        send_read(6'd0, W_IDLE);
        drain();

        // widest timeout and zero idle gap: fill the table until it overflows
        set_registers(32'hFFFF_FFFF, 32'd0);
        tick = 32'd1000;
        for (int i = 0; i < 75; i++)
        begin
            tick = tick + $urandom_range(1, 50);
            if (i % 9 == 8) send_random_read();
            else send_packet(random_key(), 1'b0, tick, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 1'b0);
        end
        drain();

        // zero timeout and widest idle gap: each later packet frees older flows
        set_registers(32'd0, 32'hFFFF_FFFF);
        foreach (flow_pool[i]) flow_pool[i] = random_key();
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 4) == 0) send_random_read();
            else send_pool_packet(4, $urandom_range(0, 1) ? 1 : 300);
        end
        drain();

        // mid-range settings, mostly traffic on a small set of live flows
        for (int phase = 0; phase < 3; phase++)
        begin
            set_registers($urandom_range(800, 6000), $urandom_range(20, 400));
            foreach (flow_pool[i]) flow_pool[i] = random_key();
            for (int i = 0; i < 90; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send_packet(random_key(), 1'b0, tick, 16'($urandom_range(0, 65535)),
                                   8'($urandom_range(0, 255)), 1'b0);
                    1, 2: send_random_read();
                    3: begin
                        tick = tick + 32'd10000;
                        send_pool_packet(12, 10);
                    end
                    default: send_pool_packet(12, 600);
                endcase
            end
            drain();
        end

        repeat (120) @(posedge clk);
        $display("Covered %0d created, %0d matched, %0d table-full and %0d read beats",
                 n_created, n_matched, n_full, n_reads);
        $display("across default, extreme and mid-range timeout / idle-gap settings");
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
